@@ hw/rtl/dtfe_pkg.sv @@
// Shared types, constants and tables for the digit tube flip effect sequencer.
package dtfe_pkg;

    localparam int TUBE_COUNT = 6;
    localparam logic [3:0] TOP_DIGIT = 4'd9;
    localparam logic [5:0] MAX_BRIGHT_RESET = 6'd23;
    localparam logic [5:0] SCRIPT_END = 6'd43;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_TIME    = 2'd0,
        OP_SECONDS = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        MODE_NONE    = 3'd0,
        MODE_SMOOTH  = 3'd1,
        MODE_LIST    = 3'd2,
        MODE_CATHODE = 3'd3,
        MODE_TRAIN   = 3'd4,
        MODE_ELASTIC = 3'd5,
        MODE_RSVD6   = 3'd6,
        MODE_RSVD7   = 3'd7
    } t_mode;

    localparam logic CFG_EFFECT_MODE = 1'b0;
    localparam logic CFG_MAX_BRIGHT  = 1'b1;

    typedef logic [3:0] t_digit;
    typedef t_digit [TUBE_COUNT-1:0] t_digits;

    // classified item passed from front to back
    typedef struct packed {
        t_op     op;
        t_digits digits;
    } t_item;

    // one result item
    typedef struct packed {
        t_digits    digits;
        logic [5:0] anode_mask;
        logic [5:0] fade_level;
        logic [5:0] fade_mask;
        logic       busy;
    } t_result;

    function automatic t_digit cathode_order(input logic [3:0] pos);
        t_digit d;
        unique case (pos)
            4'd0: d = 4'd1;
            4'd1: d = 4'd6;
            4'd2: d = 4'd2;
            4'd3: d = 4'd7;
            4'd4: d = 4'd5;
            4'd5: d = 4'd0;
            4'd6: d = 4'd4;
            4'd7: d = 4'd9;
            4'd8: d = 4'd8;
            4'd9: d = 4'd3;
            4'd10: d = 4'd1;
            4'd11: d = 4'd6;
            4'd12: d = 4'd2;
            4'd13: d = 4'd7;
            4'd14: d = 4'd5;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

    function automatic logic [3:0] cathode_index(input t_digit d);
        logic [3:0] r;
        unique case (d)
            4'd1: r = 4'd0;
            4'd6: r = 4'd1;
            4'd2: r = 4'd2;
            4'd7: r = 4'd3;
            4'd5: r = 4'd4;
            4'd0: r = 4'd5;
            4'd4: r = 4'd6;
            4'd9: r = 4'd7;
            4'd8: r = 4'd8;
            4'd3: r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] script_code(input logic [5:0] s);
        logic [3:0] c;
        unique case (s)
            6'd0: c = 4'd0;   6'd1: c = 4'd1;   6'd2: c = 4'd6;   6'd3: c = 4'd1;
            6'd4: c = 4'd5;   6'd5: c = 4'd6;   6'd6: c = 4'd1;   6'd7: c = 4'd4;
            6'd8: c = 4'd5;   6'd9: c = 4'd6;   6'd10: c = 4'd1;  6'd11: c = 4'd3;
            6'd12: c = 4'd4;  6'd13: c = 4'd5;  6'd14: c = 4'd6;  6'd15: c = 4'd1;
            6'd16: c = 4'd2;  6'd17: c = 4'd3;  6'd18: c = 4'd4;  6'd19: c = 4'd5;
            6'd20: c = 4'd6;  6'd21: c = 4'd1;  6'd22: c = 4'd13; 6'd23: c = 4'd2;
            6'd24: c = 4'd3;  6'd25: c = 4'd4;  6'd26: c = 4'd5;  6'd27: c = 4'd6;
            6'd28: c = 4'd12; 6'd29: c = 4'd2;  6'd30: c = 4'd3;  6'd31: c = 4'd4;
            6'd32: c = 4'd5;  6'd33: c = 4'd11; 6'd34: c = 4'd2;  6'd35: c = 4'd3;
            6'd36: c = 4'd4;  6'd37: c = 4'd10; 6'd38: c = 4'd2;  6'd39: c = 4'd3;
            6'd40: c = 4'd9;  6'd41: c = 4'd2;  6'd42: c = 4'd8;  6'd43: c = 4'd15;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/dtfe_front.sv @@
// Front end: accepts items, saturates digits and queues them for the back end.
module dtfe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_operation,
    input  logic [3:0]      i_hour_tens,
    input  logic [3:0]      i_hour_ones,
    input  logic [3:0]      i_minute_tens,
    input  logic [3:0]      i_minute_ones,
    input  logic [3:0]      i_second_tens,
    input  logic [3:0]      i_second_ones,
    output logic            o_q_valid,
    output dtfe_pkg::t_item o_q_item,
    input  logic            i_q_take
);
    import dtfe_pkg::*;

    t_item r_q [QUEUE_DEPTH];
    logic  r_rd, r_wr;
    logic [1:0] r_cnt;
    t_item w_item;
    logic  w_push;

    function automatic t_digit sat(input logic [3:0] v);
        return (v > TOP_DIGIT) ? TOP_DIGIT : v;
    endfunction

    always_comb begin
        w_item.op = t_op'(i_operation);
        w_item.digits[0] = sat(i_hour_tens);
        w_item.digits[1] = sat(i_hour_ones);
        w_item.digits[2] = sat(i_minute_tens);
        w_item.digits[3] = sat(i_minute_ones);
        w_item.digits[4] = sat(i_second_tens);
        w_item.digits[5] = sat(i_second_ones);
    end

    assign o_stall   = (r_cnt == 2'(QUEUE_DEPTH));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_item;
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (i_q_take) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_take);
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_take |-> o_q_valid) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QUEUE_DEPTH)) else $error("queue count overrun");
    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_q_take) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count missed a push");
endmodule

@@ hw/rtl/dtfe_back.sv @@
// Back end: effect state and one frame of work per tick, registered result.
module dtfe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  dtfe_pkg::t_item   i_q_item,
    output logic              o_q_take,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [5:0]        i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output dtfe_pkg::t_result o_result
);
    import dtfe_pkg::*;

    t_mode r_mode;
    logic [5:0] r_maxb;
    t_digits r_shown, r_target, r_cpos, r_cgoal;
    logic [5:0] r_lit, r_chg, r_bright, r_stage;
    logic r_fup, r_act, r_tp, r_sp, r_leave;
    logic [2:0] r_lamp;
    logic r_ovalid;
    t_result r_res;

    t_digits n_shown, n_target, n_cpos, n_cgoal;
    logic [5:0] n_lit, n_chg, n_bright, n_stage, w_diff;
    logic n_fup, n_act, n_tp, n_sp, n_leave;
    logic [2:0] n_lamp;
    logic [3:0] w_code;
    logic [2:0] w_lmp;
    t_result w_res;

    assign o_q_take = i_q_valid && (!r_ovalid || !i_stall);
    assign o_valid  = r_ovalid;
    assign o_result = r_res;

    always_comb begin
        n_shown = r_shown; n_target = r_target; n_cpos = r_cpos; n_cgoal = r_cgoal;
        n_lit = r_lit; n_chg = r_chg; n_bright = r_bright; n_stage = r_stage;
        n_fup = r_fup; n_act = r_act; n_tp = r_tp; n_sp = r_sp; n_leave = r_leave;
        n_lamp = r_lamp;
        w_code = 4'd0;
        w_lmp = 3'd0;
        for (int i = 0; i < TUBE_COUNT; i++) w_diff[i] = (r_shown[i] != r_target[i]);
        unique case (i_q_item.op)
            OP_TIME: begin
                n_target = i_q_item.digits;
                n_tp = 1'b1;
            end
            OP_SECONDS: begin
                n_target[4] = i_q_item.digits[4];
                n_target[5] = i_q_item.digits[5];
                n_sp = 1'b1;
            end
            OP_TICK: begin
                unique case (r_mode)
                    MODE_NONE: begin
                        n_shown = r_target; n_tp = 1'b0; n_sp = 1'b0;
                    end
                    MODE_SMOOTH: begin
                        if (r_sp) begin
                            n_shown[4] = r_target[4]; n_shown[5] = r_target[5];
                            n_sp = 1'b0;
                        end
                        if (r_tp) begin
                            if (!r_act) begin
                                n_act = 1'b1; n_fup = 1'b0;
                                for (int i = 0; i < TUBE_COUNT; i++)
                                    n_chg[i] = (n_shown[i] != r_target[i]);
                            end
                            if (!n_fup) begin
                                if (r_bright <= 6'd1) begin
                                    n_bright = 6'd0; n_fup = 1'b1; n_shown = r_target;
                                end else n_bright = r_bright - 6'd1;
                            end else if ({1'b0, r_bright} + 7'd1 >= {1'b0, r_maxb}) begin
                                n_fup = 1'b0; n_bright = r_maxb; n_act = 1'b0; n_tp = 1'b0;
                            end else n_bright = r_bright + 6'd1;
                        end
                    end
                    MODE_LIST: begin
                        if (!r_act) begin
                            n_act = 1'b1; n_chg = w_diff;
                        end
                        for (int i = 0; i < TUBE_COUNT; i++) begin
                            if (n_chg[i]) begin
                                n_shown[i] = (r_shown[i] == 4'd0) ? TOP_DIGIT
                                                                  : r_shown[i] - 4'd1;
                                if (n_shown[i] == r_target[i]) n_chg[i] = 1'b0;
                            end
                        end
                        if (n_chg == 6'd0) begin
                            n_act = 1'b0; n_tp = 1'b0; n_sp = 1'b0;
                        end
                    end
                    MODE_CATHODE: begin
                        if (!r_act) begin
                            n_act = 1'b1; n_chg = w_diff;
                            for (int i = 0; i < TUBE_COUNT; i++) begin
                                if (w_diff[i]) begin
                                    n_cpos[i] = cathode_index(r_shown[i]);
                                    n_cgoal[i] = cathode_index(r_target[i]);
                                end
                            end
                        end
                        for (int i = 0; i < TUBE_COUNT; i++) begin
                            if (n_chg[i]) begin
                                if (n_cpos[i] > n_cgoal[i]) begin
                                    n_cpos[i] = n_cpos[i] - 4'd1;
                                    n_shown[i] = cathode_order(n_cpos[i]);
                                end else if (n_cpos[i] < n_cgoal[i]) begin
                                    n_cpos[i] = n_cpos[i] + 4'd1;
                                    n_shown[i] = cathode_order(n_cpos[i]);
                                end else n_chg[i] = 1'b0;
                            end
                        end
                        if (n_chg == 6'd0) begin
                            n_act = 1'b0; n_tp = 1'b0; n_sp = 1'b0;
                        end
                    end
                    MODE_TRAIN: begin
                        if (!r_tp) begin
                            if (r_sp) begin
                                n_shown[4] = r_target[4]; n_shown[5] = r_target[5];
                                n_sp = 1'b0;
                            end
                        end else begin
                            if (!r_act) begin
                                n_act = 1'b1; n_lamp = 3'd0; n_leave = 1'b1;
                            end
                            w_lmp = (n_lamp > 3'd5) ? 3'd5 : n_lamp;
                            if (n_leave) begin
                                for (int i = 1; i < TUBE_COUNT; i++)
                                    if (3'(i) > w_lmp) n_shown[i] = r_shown[i-1];
                                n_lit[w_lmp] = 1'b0;
                                if (w_lmp == 3'd5) begin
                                    n_leave = 1'b0; n_lamp = 3'd0;
                                end else n_lamp = w_lmp + 3'd1;
                            end else begin
                                for (int i = 1; i < TUBE_COUNT; i++)
                                    if (3'(i) <= w_lmp) n_shown[i] = r_shown[i-1];
                                n_shown[0] = r_target[3'd5 - w_lmp];
                                n_lit[w_lmp] = 1'b1;
                                if (w_lmp == 3'd5) begin
                                    n_act = 1'b0; n_tp = 1'b0; n_lamp = 3'd6;
                                end else n_lamp = w_lmp + 3'd1;
                            end
                        end
                    end
                    MODE_ELASTIC: begin
                        if (!r_tp) begin
                            if (r_sp) begin
                                n_shown[4] = r_target[4]; n_shown[5] = r_target[5];
                                n_sp = 1'b0;
                            end
                        end else begin
                            if (!r_act) begin
                                n_act = 1'b1; n_stage = 6'd0;
                            end
                            w_code = script_code(n_stage);
                            n_stage = n_stage + 6'd1;
                            if (w_code == 4'd1) n_lit[5] = 1'b0;
                            else if (w_code >= 4'd2 && w_code <= 4'd6) begin
                                w_lmp = 3'(w_code - 4'd2);
                                n_lit[w_lmp] = 1'b0;
                                n_shown[w_lmp + 3'd1] = r_shown[w_lmp];
                                n_lit[w_lmp + 3'd1] = 1'b1;
                            end else if (w_code >= 4'd8 && w_code <= 4'd13) begin
                                n_shown[0] = r_target[3'(w_code - 4'd8)];
                                n_lit[0] = 1'b1;
                            end else if (w_code == 4'd15) begin
                                n_act = 1'b0; n_tp = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        w_res.digits = n_shown;
        w_res.anode_mask = n_lit;
        w_res.fade_level = n_bright;
        w_res.fade_mask = (r_mode == MODE_SMOOTH) ? n_chg : 6'd0;
        w_res.busy = n_act;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_take) r_res <= w_res;
        if (!i_rst_n) begin
            r_mode <= MODE_NONE; r_maxb <= MAX_BRIGHT_RESET;
            r_shown <= '0; r_target <= '0; r_cpos <= '0; r_cgoal <= '0;
            r_lit <= 6'h3f; r_chg <= '0; r_bright <= MAX_BRIGHT_RESET; r_stage <= '0;
            r_fup <= 1'b0; r_act <= 1'b0; r_tp <= 1'b0; r_sp <= 1'b0;
            r_leave <= 1'b1; r_lamp <= '0; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_EFFECT_MODE: r_mode <= t_mode'(i_cfg_data[2:0]);
                    CFG_MAX_BRIGHT:  r_maxb <= i_cfg_data;
                endcase
            end
            if (o_q_take) begin
                r_shown <= n_shown; r_target <= n_target; r_cpos <= n_cpos;
                r_cgoal <= n_cgoal; r_lit <= n_lit; r_chg <= n_chg;
                r_bright <= n_bright; r_stage <= n_stage; r_fup <= n_fup;
                r_act <= n_act; r_tp <= n_tp; r_sp <= n_sp; r_leave <= n_leave;
                r_lamp <= n_lamp;
                r_ovalid <= 1'b1;
            end else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_result))
        else $error("result changed under stall");
    a_take_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !o_q_take) else $error("item taken while result stalled");
    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.busy == r_act) else $error("busy flag out of step");
endmodule

@@ hw/rtl/digit_tube_flip_effect_sequencer.sv @@
// Top level of the digit tube flip effect sequencer.
// A two-entry queue parts the front and back ends; the back end registers each result.
// Throughput: one item per cycle while the output is not stalled.
// A stalled output holds its result while the queue fills, then input stalls.
// Reset (synchronous, active low) clears all effect state:
// digits zero, all tubes lit, brightness 23, mode none.
module digit_tube_flip_effect_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_operation,
    input  logic [3:0] i_hour_tens,
    input  logic [3:0] i_hour_ones,
    input  logic [3:0] i_minute_tens,
    input  logic [3:0] i_minute_ones,
    input  logic [3:0] i_second_tens,
    input  logic [3:0] i_second_ones,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [5:0] i_cfg_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_tube0_digit,
    output logic [3:0] o_tube1_digit,
    output logic [3:0] o_tube2_digit,
    output logic [3:0] o_tube3_digit,
    output logic [3:0] o_tube4_digit,
    output logic [3:0] o_tube5_digit,
    output logic [5:0] o_anode_mask,
    output logic [5:0] o_fade_level,
    output logic [5:0] o_fade_mask,
    output logic       o_effect_busy
);
    import dtfe_pkg::*;

    logic    w_qv, w_take;
    t_item   w_item;
    t_result w_res;

    dtfe_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_operation,
        .i_hour_tens, .i_hour_ones, .i_minute_tens, .i_minute_ones,
        .i_second_tens, .i_second_ones,
        .o_q_valid(w_qv), .o_q_item(w_item), .i_q_take(w_take)
    );

    dtfe_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .i_q_item(w_item), .o_q_take(w_take),
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_valid, .i_stall, .o_result(w_res)
    );

    assign o_tube0_digit = w_res.digits[0];
    assign o_tube1_digit = w_res.digits[1];
    assign o_tube2_digit = w_res.digits[2];
    assign o_tube3_digit = w_res.digits[3];
    assign o_tube4_digit = w_res.digits[4];
    assign o_tube5_digit = w_res.digits[5];
    assign o_anode_mask  = w_res.anode_mask;
    assign o_fade_level  = w_res.fade_level;
    assign o_fade_mask   = w_res.fade_mask;
    assign o_effect_busy = w_res.busy;
endmodule

@@ bench/digit_tube_flip_effect_sequencer_test.sv @@
// Self-checking bench for the digit tube flip effect sequencer, with its own predictor.
`timescale 1ns / 100ps

module digit_tube_flip_effect_sequencer_test;
    import dtfe_pkg::*;

    class tube_scoreboard;
        t_result    shown_q[$];
        int         errors;
        logic [2:0] mode;
        logic [5:0] max_bright;
        logic [3:0] shown[6];
        logic [3:0] goal[6];
        logic [3:0] cpos[6];
        logic [3:0] cgoal[6];
        logic [5:0] lit;
        logic [5:0] changing;
        logic [5:0] bright;
        logic [5:0] stage;
        logic [2:0] lamp_idx;
        bit         fading_up, active, time_pend, sec_pend, leaving;
        logic [3:0] order[10] = '{1, 6, 2, 7, 5, 0, 4, 9, 8, 3};
        logic [3:0] moves[44] = '{0, 1, 6, 1, 5, 6, 1, 4, 5, 6, 1, 3, 4, 5, 6, 1, 2, 3, 4,
                                  5, 6, 1, 13, 2, 3, 4, 5, 6, 12, 2, 3, 4, 5, 11, 2, 3, 4,
                                  10, 2, 3, 9, 2, 8, 15};

        function new();
            mode = MODE_NONE;
            max_bright = MAX_BRIGHT_RESET;
            for (int i = 0; i < 6; i++) begin
                shown[i] = 0; goal[i] = 0; cpos[i] = 0; cgoal[i] = 0;
            end
            lit = 6'h3f; changing = 0; bright = MAX_BRIGHT_RESET; stage = 0; lamp_idx = 0;
            fading_up = 0; active = 0; time_pend = 0; sec_pend = 0; leaving = 1;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [5:0] v);
            if (idx == CFG_EFFECT_MODE) mode = v[2:0];
            else max_bright = v;
        endfunction

        function logic [5:0] changed_tubes();
            logic [5:0] m;
            m = 0;
            for (int i = 0; i < 6; i++) if (shown[i] != goal[i]) m[i] = 1'b1;
            return m;
        endfunction

        function logic [3:0] cathode_slot(logic [3:0] d);
            logic [3:0] r;
            r = 0;
            for (int c = 0; c < 10; c++) if (order[c] == d) r = 4'(c);
            return r;
        endfunction

        function void take_seconds();
            shown[4] = goal[4]; shown[5] = goal[5]; sec_pend = 0;
        endfunction

        function void end_if_settled();
            if (changing == 0) begin
                active = 0; time_pend = 0; sec_pend = 0;
            end
        endfunction

        function void frame_smooth();
            if (sec_pend) take_seconds();
            if (!time_pend) return;
            if (!active) begin
                active = 1; fading_up = 0; changing = changed_tubes();
            end
            if (!fading_up) begin
                if (bright <= 1) begin
                    bright = 0; fading_up = 1;
                    for (int i = 0; i < 6; i++) shown[i] = goal[i];
                end else bright--;
            end else if ({1'b0, bright} + 7'd1 >= {1'b0, max_bright}) begin
                fading_up = 0; bright = max_bright; active = 0; time_pend = 0;
            end else bright++;
        endfunction

        function void frame_list();
            if (!active) begin
                active = 1; changing = changed_tubes();
            end
            for (int i = 0; i < 6; i++) begin
                if (changing[i]) begin
                    shown[i] = (shown[i] == 0) ? 4'd9 : shown[i] - 4'd1;
                    if (shown[i] == goal[i]) changing[i] = 1'b0;
                end
            end
            end_if_settled();
        endfunction

        function void frame_cathode();
            if (!active) begin
                active = 1; changing = changed_tubes();
                for (int i = 0; i < 6; i++) begin
                    if (changing[i]) begin
                        cpos[i] = cathode_slot(shown[i]);
                        cgoal[i] = cathode_slot(goal[i]);
                    end
                end
            end
            for (int i = 0; i < 6; i++) begin
                if (changing[i]) begin
                    if (cpos[i] > cgoal[i]) begin
                        cpos[i]--; shown[i] = order[cpos[i] % 10];
                    end else if (cpos[i] < cgoal[i]) begin
                        cpos[i]++; shown[i] = order[cpos[i] % 10];
                    end else changing[i] = 1'b0;
                end
            end
            end_if_settled();
        endfunction

        function void frame_train();
            int lamp;
            if (!time_pend) begin
                if (sec_pend) take_seconds();
                return;
            end
            if (!active) begin
                active = 1; lamp_idx = 0; leaving = 1;
            end
            lamp = (lamp_idx > 5) ? 5 : lamp_idx;
            if (leaving) begin
                for (int i = 5; i > lamp; i--) shown[i] = shown[i-1];
                lit[lamp] = 1'b0;
                lamp++;
                if (lamp >= 6) begin
                    leaving = 0; lamp = 0;
                end
            end else begin
                for (int i = lamp; i > 0; i--) shown[i] = shown[i-1];
                shown[0] = goal[5-lamp];
                lit[lamp] = 1'b1;
                lamp++;
                if (lamp >= 6) begin
                    active = 0; time_pend = 0;
                end
            end
            lamp_idx = lamp[2:0];
        endfunction

        function void frame_elastic();
            logic [3:0] code;
            int k;
            if (!time_pend) begin
                if (sec_pend) take_seconds();
                return;
            end
            if (!active) begin
                active = 1; stage = 0;
            end
            code = (stage < 44) ? moves[stage] : 4'd0;
            stage = stage + 6'd1;
            if (code == 1) lit[5] = 1'b0;
            else if (code >= 2 && code <= 6) begin
                k = code - 2;
                lit[k] = 1'b0;
                shown[k+1] = shown[k];
                lit[k+1] = 1'b1;
            end else if (code >= 8 && code <= 13) begin
                shown[0] = goal[code-8];
                lit[0] = 1'b1;
            end else if (code == 15) begin
                active = 0; time_pend = 0;
            end
        endfunction

        function void note_item(t_op op, t_digits d);
            t_result r;
            if (op == OP_TIME) begin
                for (int i = 0; i < 6; i++) goal[i] = (d[i] > 9) ? 4'd9 : d[i];
                time_pend = 1;
            end else if (op == OP_SECONDS) begin
                for (int i = 4; i < 6; i++) goal[i] = (d[i] > 9) ? 4'd9 : d[i];
                sec_pend = 1;
            end else if (op == OP_TICK) begin
                case (mode)
                    MODE_NONE: begin
                        for (int i = 0; i < 6; i++) shown[i] = goal[i];
                        time_pend = 0; sec_pend = 0;
                    end
                    MODE_SMOOTH:  frame_smooth();
                    MODE_LIST:    frame_list();
                    MODE_CATHODE: frame_cathode();
                    MODE_TRAIN:   frame_train();
                    MODE_ELASTIC: frame_elastic();
                    default: ;
                endcase
            end
            for (int i = 0; i < 6; i++) r.digits[i] = shown[i];
            r.anode_mask = lit;
            r.fade_level = bright;
            r.fade_mask = (mode == MODE_SMOOTH) ? changing : 6'd0;
            r.busy = active;
            shown_q.push_back(r);
        endfunction

        function void compare(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_result act);
            t_result want;
            if (shown_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item, got %h", $time, act);
                return;
            end
            want = shown_q.pop_front();
            for (int i = 0; i < 6; i++)
                compare($sformatf("tube%0d_digit", i), want.digits[i], act.digits[i]);
            compare("anode_mask", want.anode_mask, act.anode_mask);
            compare("fade_level", want.fade_level, act.fade_level);
            compare("fade_mask", want.fade_mask, act.fade_mask);
            compare("effect_busy", want.busy, act.busy);
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_valid = 0;
    logic       o_stall;
    logic [1:0] i_operation = 0;
    logic [3:0] i_hour_tens = 0, i_hour_ones = 0, i_minute_tens = 0, i_minute_ones = 0;
    logic [3:0] i_second_tens = 0, i_second_ones = 0;
    logic       i_cfg_we = 0;
    logic       i_cfg_index = 0;
    logic [5:0] i_cfg_data = 0;
    logic       o_valid;
    logic       i_stall = 0;
    logic [3:0] o_tube0_digit, o_tube1_digit, o_tube2_digit;
    logic [3:0] o_tube3_digit, o_tube4_digit, o_tube5_digit;
    logic [5:0] o_anode_mask, o_fade_level, o_fade_mask;
    logic       o_effect_busy;

    tube_scoreboard sb = new();
    int send_idle_pct = 38;
    int recv_stall_pct = 78;
    int items_sent = 0;

    digit_tube_flip_effect_sequencer u_top (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) i_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge i_clk) begin
        t_result act;
        if (i_rst_n && o_valid && !i_stall) begin
            act.digits = {o_tube5_digit, o_tube4_digit, o_tube3_digit,
                          o_tube2_digit, o_tube1_digit, o_tube0_digit};
            act.anode_mask = o_anode_mask;
            act.fade_level = o_fade_level;
            act.fade_mask = o_fade_mask;
            act.busy = o_effect_busy;
            sb.check_result(act);
        end
    end

    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    // swap idle profiles as the run goes through its thirds
    task automatic send_item(t_op op, t_digits d);
        items_sent++;
        if (items_sent == 133) begin
            send_idle_pct = 78; recv_stall_pct = 38;
        end else if (items_sent == 266) begin
            send_idle_pct = 0; recv_stall_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        {i_second_ones, i_second_tens, i_minute_ones, i_minute_tens, i_hour_ones, i_hour_tens}
            <= d;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(op, d);
    endtask

    task automatic write_reg(logic idx, logic [5:0] v);
        i_valid <= 1'b0;
        while (sb.shown_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    function automatic t_digits rand_digits();
        t_digits d;
        for (int i = 0; i < 6; i++)
            d[i] = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
        return d;
    endfunction

    task automatic tick();
        send_item(OP_TICK, rand_digits());
    endtask

    // time change followed by a run of frames, with the odd stray item mixed in
    task automatic random_run(int count, int frames);
        int n;
        n = 0;
        while (n < count) begin
            send_item(OP_TIME, rand_digits());
            n++;
            for (int f = $urandom_range(frames); f > 0 && n < count; f--) begin
                case ($urandom_range(19))
                    0: send_item(OP_SECONDS, rand_digits());
                    1: send_item(OP_TIME, rand_digits());
                    2: send_item(OP_NONE, rand_digits());
                    default: tick();
                endcase
                n++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // mode none: extremes, saturation, seconds only, idle operation
        send_item(OP_TIME, {6{4'd9}});
        tick();
        send_item(OP_TIME, {6{4'hf}});
        send_item(OP_SECONDS, {6{4'ha}});
        tick();
        send_item(OP_SECONDS, {6{4'd0}});
        send_item(OP_NONE, {6{4'hf}});
        tick();
        send_item(OP_TIME, {4'd3, 4'd5, 4'd7, 4'd2, 4'd4, 4'd8});

        // zero and full brightness, then smooth fades
        write_reg(CFG_MAX_BRIGHT, 6'd0);
        write_reg(CFG_EFFECT_MODE, 6'(MODE_SMOOTH));
        repeat (26) tick();
        write_reg(CFG_MAX_BRIGHT, 6'd63);
        send_item(OP_TIME, {6{4'd1}});
        repeat (70) tick();

        // undefined modes leave the display alone
        write_reg(CFG_EFFECT_MODE, 6'(MODE_RSVD6));
        send_item(OP_TIME, rand_digits());
        tick();
        write_reg(CFG_EFFECT_MODE, 6'(MODE_RSVD7));
        tick();

        for (int p = 0; p < 12; p++) begin
            logic [2:0] m;
            m = 3'($urandom_range(5));
            if (p < 6) m = 3'(p);
            write_reg(CFG_EFFECT_MODE, 6'(m));
            write_reg(CFG_MAX_BRIGHT, (p % 3 == 0) ? 6'd1 : 6'($urandom_range(63)));
            random_run(24, (m == MODE_ELASTIC) ? 50 : (m == MODE_SMOOTH) ? 40 : 15);
        end

        i_valid <= 1'b0;
        while (sb.shown_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
